@@ design/nrr_pkg.sv @@
// Shared constants, register and method codes, and controller states of the nth-root refiner.
package nrr_pkg;

    localparam int DW            = 64;
    localparam int DEF_INT_BITS  = 24;
    localparam int DEF_FRAC_BITS = 16;
    localparam int CNT_W         = 7;

    localparam logic [1:0] REG_DEGREE = 2'd0;
    localparam logic [1:0] REG_ITERS  = 2'd1;
    localparam logic [1:0] REG_METHOD = 2'd2;

    localparam logic [1:0] METH_NEWTON = 2'd0;
    localparam logic [1:0] METH_SECANT = 2'd1;
    localparam logic [1:0] METH_FIXED  = 2'd2;
    // no refinement, the seed is the answer
    localparam logic [1:0] METH_NONE   = 2'd3;

    localparam logic [3:0] DEGREE_RST = 4'd2;
    localparam logic [4:0] ITERS_RST  = 5'd4;
    localparam logic [1:0] METHOD_RST = METH_NEWTON;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SEED_MID,
        ST_SEED_POW,
        ST_REF,
        ST_POW,
        ST_POW_MUL,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_NT1,
        ST_NT2,
        ST_NT3,
        ST_FX1,
        ST_FX2,
        ST_FX3,
        ST_FX4,
        ST_SC1,
        ST_SC2,
        ST_SC3,
        ST_APPLY,
        ST_DONE
    } state_t;

endpackage

@@ design/nth_root_refiner_unit.sv @@
// Top level of the nth-root refiner: config port, seed search and refinement sequencer.
// Takes one item at a time: start is accepted while busy is low, and the result appears on
// root_value and status for a single cycle with done high; it cannot be held off. All work
// goes through one bit-serial multiplier and one bit-serial divider. The seed search does
// up to (INT_BITS+1)*k multiplies; a Newton step costs k+1 multiplies and a divide, a
// fixed-point step k multiplies and two divides, a secant step 2k+1 multiplies and a
// divide. Items are shortest for a radicand below one (zero seed) and longest for a large
// radicand at degree 8 with 16 steps.
module nth_root_refiner_unit #(
    parameter int INT_BITS  = nrr_pkg::DEF_INT_BITS,
    parameter int FRAC_BITS = nrr_pkg::DEF_FRAC_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [INT_BITS+FRAC_BITS-1:0]  radicand,
    output logic                           done,
    output logic [INT_BITS+FRAC_BITS-1:0]  root_value,
    output logic                           status,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [3:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    localparam int DW = nrr_pkg::DW;
    localparam int W  = INT_BITS + FRAC_BITS;
    localparam int SW = INT_BITS + 1;
    localparam logic [DW-1:0] WMASK64 = (DW'(1) << W) - DW'(1);
    localparam logic [DW-1:0] ONEQ    = DW'(1) << FRAC_BITS;

    // configuration
    logic [3:0] degree_reg;
    logic [4:0] iters_reg;
    logic [1:0] method_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_reg <= nrr_pkg::DEGREE_RST;
            iters_reg  <= nrr_pkg::ITERS_RST;
            method_reg <= nrr_pkg::METHOD_RST;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[3:2])
                nrr_pkg::REG_DEGREE: degree_reg <= pwdata[3:0];
                nrr_pkg::REG_ITERS:  iters_reg  <= pwdata[4:0];
                nrr_pkg::REG_METHOD: method_reg <= pwdata[1:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            nrr_pkg::REG_DEGREE: prdata = {28'd0, degree_reg};
            nrr_pkg::REG_ITERS:  prdata = {27'd0, iters_reg};
            nrr_pkg::REG_METHOD: prdata = {30'd0, method_reg};
            default:             prdata = '0;
        endcase
    end

    // arithmetic units
    logic [DW-1:0]    mul_a_reg, mul_a_next;
    logic [DW-1:0]    mul_b_reg, mul_b_next;
    logic             mul_start, mul_done;
    logic [2*DW-1:0]  mul_prod;
    logic [2*DW-1:0]  div_num_reg, div_num_next;
    logic [DW-1:0]    div_den_reg, div_den_next;
    logic             div_start, div_done, div_fault;
    logic [DW-1:0]    div_quot;

    nrr_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a_reg),
        .b     (mul_b_reg),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    nrr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num_reg),
        .den   (div_den_reg),
        .done  (div_done),
        .fault (div_fault),
        .quot  (div_quot)
    );

    // sequencer
    nrr_pkg::state_t state_reg, state_next;
    nrr_pkg::state_t ret_reg, ret_next;
    nrr_pkg::state_t pow_ret_reg, pow_ret_next;

    logic [W-1:0]   n_reg, n_next;
    logic [3:0]     k_reg, k_next;
    logic [1:0]     meth_reg, meth_next;
    logic [4:0]     steps_reg, steps_next;
    logic [SW-1:0]  lo_reg, lo_next;
    logic [SW-1:0]  hi_reg, hi_next;
    logic [SW-1:0]  mid_reg, mid_next;
    logic [SW-1:0]  best_reg, best_next;
    logic [3:0]     scnt_reg, scnt_next;
    logic [W-1:0]   x_reg, x_next;
    logic [DW-1:0]  b_reg, b_next;
    logic [DW-1:0]  p_reg, p_next;
    logic [DW-1:0]  pbase_reg, pbase_next;
    logic [3:0]     pcnt_reg, pcnt_next;
    logic [DW-1:0]  t_reg, t_next;
    logic           down_reg, down_next;
    logic           fault_reg, fault_next;
    logic           done_reg, done_next;
    logic           status_reg, status_next;
    logic [W-1:0]   root_reg, root_next;

    logic [DW-1:0]  x64, n64, lim64, qm_val, mag;
    logic           qm_over;
    logic [SW:0]    mid_sum;
    logic [3:0]     k_cl;
    logic [4:0]     it_cl;

    assign x64     = DW'(x_reg);
    assign n64     = DW'(n_reg);
    assign lim64   = DW'(n_reg[W-1:FRAC_BITS]);
    assign qm_val  = mul_prod[DW-1+FRAC_BITS:FRAC_BITS];
    assign qm_over = |mul_prod[2*DW-1:DW+FRAC_BITS];
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mag     = (t_reg > n64) ? t_reg - n64 : n64 - t_reg;

    assign k_cl  = (degree_reg < 4'd2) ? 4'd2 : ((degree_reg > 4'd8) ? 4'd8 : degree_reg);
    assign it_cl = (iters_reg == 5'd0) ? 5'd1 : ((iters_reg > 5'd16) ? 5'd16 : iters_reg);

    assign busy       = (state_reg != nrr_pkg::ST_IDLE);
    assign done       = done_reg;
    assign status     = status_reg;
    assign root_value = root_reg;

    always_comb
    begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        pow_ret_next = pow_ret_reg;
        n_next       = n_reg;
        k_next       = k_reg;
        meth_next    = meth_reg;
        steps_next   = steps_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        best_next    = best_reg;
        scnt_next    = scnt_reg;
        x_next       = x_reg;
        b_next       = b_reg;
        p_next       = p_reg;
        pbase_next   = pbase_reg;
        pcnt_next    = pcnt_reg;
        t_next       = t_reg;
        down_next    = down_reg;
        fault_next   = fault_reg;
        mul_a_next   = mul_a_reg;
        mul_b_next   = mul_b_reg;
        div_num_next = div_num_reg;
        div_den_next = div_den_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        root_next    = root_reg;
        mul_start    = 1'b0;
        div_start    = 1'b0;

        unique case (state_reg)
            nrr_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    n_next     = radicand;
                    k_next     = k_cl;
                    meth_next  = method_reg;
                    steps_next = (method_reg == nrr_pkg::METH_SECANT && it_cl > 5'd1)
                                 ? it_cl - 5'd1 : it_cl;
                    lo_next    = '0;
                    hi_next    = SW'(radicand[W-1:FRAC_BITS]);
                    best_next  = '0;
                    fault_next = 1'b0;
                    state_next = nrr_pkg::ST_SEED_MID;
                end
            end

            // binary search for the largest integer m with m^k <= floor(n)
            nrr_pkg::ST_SEED_MID:
            begin
                if (lo_reg > hi_reg)
                begin
                    x_next     = W'(best_reg) << FRAC_BITS;
                    state_next = nrr_pkg::ST_REF;
                end
                else
                begin
                    mid_next   = mid_sum[SW:1];
                    scnt_next  = k_reg;
                    mul_a_next = DW'(1);
                    mul_b_next = DW'(mid_sum[SW:1]);
                    ret_next   = nrr_pkg::ST_SEED_POW;
                    state_next = nrr_pkg::ST_MUL_GO;
                end
            end

            nrr_pkg::ST_SEED_POW:
            begin
                if ((|mul_prod[2*DW-1:DW]) || (mul_prod[DW-1:0] > lim64))
                begin
                    hi_next    = mid_reg - SW'(1);
                    state_next = nrr_pkg::ST_SEED_MID;
                end
                else if (scnt_reg == 4'd1)
                begin
                    best_next  = mid_reg;
                    lo_next    = mid_reg + SW'(1);
                    state_next = nrr_pkg::ST_SEED_MID;
                end
                else
                begin
                    scnt_next  = scnt_reg - 4'd1;
                    mul_a_next = mul_prod[DW-1:0];
                    mul_b_next = DW'(mid_reg);
                    ret_next   = nrr_pkg::ST_SEED_POW;
                    state_next = nrr_pkg::ST_MUL_GO;
                end
            end

            nrr_pkg::ST_REF:
            begin
                p_next     = ONEQ;
                pbase_next = x64;
                pcnt_next  = k_reg - 4'd1;
                b_next     = ((x64 >> FRAC_BITS) + DW'(1)) << FRAC_BITS;
                if (steps_reg == 5'd0 || x_reg == '0)
                    state_next = nrr_pkg::ST_DONE;
                else
                begin
                    unique case (meth_reg)
                        nrr_pkg::METH_NEWTON:
                        begin
                            pow_ret_next = nrr_pkg::ST_NT1;
                            state_next   = nrr_pkg::ST_POW;
                        end
                        nrr_pkg::METH_FIXED:
                        begin
                            pow_ret_next = nrr_pkg::ST_FX1;
                            state_next   = nrr_pkg::ST_POW;
                        end
                        nrr_pkg::METH_SECANT:
                        begin
                            pcnt_next    = k_reg;
                            pow_ret_next = nrr_pkg::ST_SC1;
                            state_next   = nrr_pkg::ST_POW;
                        end
                        default: state_next = nrr_pkg::ST_DONE;
                    endcase
                end
            end

            // p = base^pcnt in fixed point, truncating after each multiply
            nrr_pkg::ST_POW:
            begin
                if (pcnt_reg == 4'd0)
                    state_next = pow_ret_reg;
                else
                begin
                    mul_a_next = p_reg;
                    mul_b_next = pbase_reg;
                    ret_next   = nrr_pkg::ST_POW_MUL;
                    state_next = nrr_pkg::ST_MUL_GO;
                end
            end

            nrr_pkg::ST_POW_MUL:
            begin
                if (qm_over)
                begin
                    fault_next = 1'b1;
                    state_next = nrr_pkg::ST_DONE;
                end
                else
                begin
                    p_next     = qm_val;
                    pcnt_next  = pcnt_reg - 4'd1;
                    state_next = nrr_pkg::ST_POW;
                end
            end

            nrr_pkg::ST_MUL_GO:
            begin
                mul_start  = 1'b1;
                state_next = nrr_pkg::ST_MUL_WAIT;
            end

            nrr_pkg::ST_MUL_WAIT:
            begin
                if (mul_done)
                    state_next = ret_reg;
            end

            nrr_pkg::ST_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = nrr_pkg::ST_DIV_WAIT;
            end

            nrr_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                    state_next = ret_reg;
            end

            nrr_pkg::ST_NT1:
            begin
                mul_a_next = p_reg;
                mul_b_next = x64;
                ret_next   = nrr_pkg::ST_NT2;
                state_next = nrr_pkg::ST_MUL_GO;
            end

            nrr_pkg::ST_NT2:
            begin
                if (qm_over)
                begin
                    fault_next = 1'b1;
                    state_next = nrr_pkg::ST_DONE;
                end
                else
                begin
                    t_next     = qm_val;
                    mul_a_next = p_reg;
                    mul_b_next = DW'(k_reg);
                    ret_next   = nrr_pkg::ST_NT3;
                    state_next = nrr_pkg::ST_MUL_GO;
                end
            end

            nrr_pkg::ST_NT3:
            begin
                if (|mul_prod[2*DW-1:DW])
                begin
                    fault_next = 1'b1;
                    state_next = nrr_pkg::ST_DONE;
                end
                else
                begin
                    down_next    = t_reg > n64;
                    div_num_next = {{DW{1'b0}}, mag} << FRAC_BITS;
                    div_den_next = mul_prod[DW-1:0];
                    ret_next     = nrr_pkg::ST_APPLY;
                    state_next   = nrr_pkg::ST_DIV_GO;
                end
            end

            nrr_pkg::ST_FX1:
            begin
                div_num_next = {{DW{1'b0}}, n64} << FRAC_BITS;
                div_den_next = p_reg;
                ret_next     = nrr_pkg::ST_FX2;
                state_next   = nrr_pkg::ST_DIV_GO;
            end

            nrr_pkg::ST_FX2:
            begin
                if (div_fault)
                begin
                    fault_next = 1'b1;
                    state_next = nrr_pkg::ST_DONE;
                end
                else
                begin
                    t_next     = div_quot;
                    mul_a_next = DW'(k_reg - 4'd1);
                    mul_b_next = x64;
                    ret_next   = nrr_pkg::ST_FX3;
                    state_next = nrr_pkg::ST_MUL_GO;
                end
            end

            nrr_pkg::ST_FX3:
            begin
                div_num_next = mul_prod + {{DW{1'b0}}, t_reg};
                div_den_next = DW'(k_reg);
                ret_next     = nrr_pkg::ST_FX4;
                state_next   = nrr_pkg::ST_DIV_GO;
            end

            nrr_pkg::ST_FX4:
            begin
                if (div_fault || div_quot > WMASK64)
                begin
                    fault_next = 1'b1;
                    state_next = nrr_pkg::ST_DONE;
                end
                else
                begin
                    x_next     = div_quot[W-1:0];
                    steps_next = steps_reg - 5'd1;
                    state_next = nrr_pkg::ST_REF;
                end
            end

            // secant: t holds x^k, then b^k is built in p
            nrr_pkg::ST_SC1:
            begin
                t_next       = p_reg;
                p_next       = ONEQ;
                pbase_next   = b_reg;
                pcnt_next    = k_reg;
                pow_ret_next = nrr_pkg::ST_SC2;
                state_next   = nrr_pkg::ST_POW;
            end

            nrr_pkg::ST_SC2:
            begin
                if (p_reg <= t_reg)
                begin
                    fault_next = 1'b1;
                    state_next = nrr_pkg::ST_DONE;
                end
                else
                begin
                    down_next    = t_reg > n64;
                    div_den_next = p_reg - t_reg;
                    mul_a_next   = mag;
                    mul_b_next   = b_reg - x64;
                    ret_next     = nrr_pkg::ST_SC3;
                    state_next   = nrr_pkg::ST_MUL_GO;
                end
            end

            nrr_pkg::ST_SC3:
            begin
                div_num_next = mul_prod;
                ret_next     = nrr_pkg::ST_APPLY;
                state_next   = nrr_pkg::ST_DIV_GO;
            end

            // x moves by the quotient; clamps at zero going down, faults past W bits going up
            nrr_pkg::ST_APPLY:
            begin
                if (div_fault)
                begin
                    fault_next = 1'b1;
                    state_next = nrr_pkg::ST_DONE;
                end
                else if (down_reg)
                begin
                    x_next     = (div_quot >= x64) ? '0 : W'(x64 - div_quot);
                    steps_next = steps_reg - 5'd1;
                    state_next = nrr_pkg::ST_REF;
                end
                else if (div_quot > (WMASK64 - x64))
                begin
                    fault_next = 1'b1;
                    state_next = nrr_pkg::ST_DONE;
                end
                else
                begin
                    x_next     = W'(x64 + div_quot);
                    steps_next = steps_reg - 5'd1;
                    state_next = nrr_pkg::ST_REF;
                end
            end

            nrr_pkg::ST_DONE:
            begin
                done_next   = 1'b1;
                status_next = fault_reg;
                root_next   = fault_reg ? WMASK64[W-1:0] : x_reg;
                state_next  = nrr_pkg::ST_IDLE;
            end

            default: state_next = nrr_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= nrr_pkg::ST_IDLE;
            ret_reg     <= nrr_pkg::ST_IDLE;
            pow_ret_reg <= nrr_pkg::ST_IDLE;
            done_reg    <= 1'b0;
            fault_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            pow_ret_reg <= pow_ret_next;
            done_reg    <= done_next;
            fault_reg   <= fault_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        k_reg       <= k_next;
        meth_reg    <= meth_next;
        steps_reg   <= steps_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        best_reg    <= best_next;
        scnt_reg    <= scnt_next;
        x_reg       <= x_next;
        b_reg       <= b_next;
        p_reg       <= p_next;
        pbase_reg   <= pbase_next;
        pcnt_reg    <= pcnt_next;
        t_reg       <= t_next;
        down_reg    <= down_next;
        mul_a_reg   <= mul_a_next;
        mul_b_reg   <= mul_b_next;
        div_num_reg <= div_num_next;
        div_den_reg <= div_den_next;
        status_reg  <= status_next;
        root_reg    <= root_next;
    end

endmodule

@@ design/nrr_mul.sv @@
// Bit-serial shift-add multiplier, 64 x 64 to 128 bits, one multiplier bit per cycle.
module nrr_mul (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [nrr_pkg::DW-1:0]     a,
    input  logic [nrr_pkg::DW-1:0]     b,
    output logic                       done,
    output logic [2*nrr_pkg::DW-1:0]   prod
);

    localparam int DW = nrr_pkg::DW;

    logic [DW-1:0]              mcand_reg;
    logic [DW-1:0]              hi_reg;
    logic [DW-1:0]              lo_reg;
    logic [nrr_pkg::CNT_W-1:0]  cnt_reg;
    logic                       run_reg;
    logic                       done_reg;
    logic [DW:0]                sum;

    assign sum  = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, mcand_reg} : {(DW+1){1'b0}});
    assign done = done_reg;
    assign prod = {hi_reg, lo_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == nrr_pkg::CNT_W'(DW - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg <= a;
            hi_reg    <= '0;
            lo_reg    <= b;
        end
        else if (run_reg)
        begin
            hi_reg <= sum[DW:1];
            lo_reg <= {sum[0], lo_reg[DW-1:1]};
        end
    end

endmodule

@@ design/nrr_div.sv @@
// Bit-serial restoring divider, 128 / 64 to 64 bits, one quotient bit per cycle.
module nrr_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [2*nrr_pkg::DW-1:0]   num,
    input  logic [nrr_pkg::DW-1:0]     den,
    output logic                       done,
    output logic                       fault,
    output logic [nrr_pkg::DW-1:0]     quot
);

    localparam int DW = nrr_pkg::DW;

    logic [DW-1:0]              rem_reg;
    logic [DW-1:0]              lo_reg;
    logic [DW-1:0]              den_reg;
    logic [nrr_pkg::CNT_W-1:0]  cnt_reg;
    logic                       run_reg;
    logic                       done_reg;
    logic                       fault_reg;
    logic [DW-1:0]              rem_sh;
    logic                       take;
    logic                       bad;

    assign rem_sh = {rem_reg[DW-2:0], lo_reg[DW-1]};
    // the bit shifted out of the top forces a subtract
    assign take   = rem_reg[DW-1] | (rem_sh >= den_reg);
    assign bad    = (den == '0) || (num[2*DW-1:DW] >= den);
    assign done   = done_reg;
    assign fault  = fault_reg;
    assign quot   = lo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            done_reg  <= 1'b0;
            fault_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                fault_reg <= bad;
                cnt_reg   <= '0;
                run_reg   <= !bad;
                done_reg  <= bad;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == nrr_pkg::CNT_W'(DW - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num[2*DW-1:DW];
            lo_reg  <= num[DW-1:0];
            den_reg <= den;
        end
        else if (run_reg)
        begin
            rem_reg <= take ? rem_sh - den_reg : rem_sh;
            lo_reg  <= {lo_reg[DW-2:0], take};
        end
    end

endmodule
